### hdl/lrbt_pkg.sv
// lrbt_pkg: shared types, register indexes and reset constants
// for the link reconnect backoff timer; no dependencies
package lrbt_pkg;

    localparam int unsigned TIME_BITS_DEF = 32;
    localparam int unsigned CFG_IDX_W     = 3;
    localparam int unsigned CFG_DATA_W    = 32;
    localparam int unsigned MS_W          = 32;
    localparam int unsigned CNT_W         = 4;

    localparam logic [CFG_IDX_W-1:0] CFG_GRACE    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INTERVAL = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BO_INIT  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_BO_MAX   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_HR_EVERY = 3'd4;

    localparam logic [MS_W-1:0]  GRACE_RST    = 32'd30000;
    localparam logic [MS_W-1:0]  INTERVAL_RST = 32'd5000;
    localparam logic [MS_W-1:0]  BO_INIT_RST  = 32'd5000;
    localparam logic [MS_W-1:0]  BO_MAX_RST   = 32'd60000;
    localparam logic [CNT_W-1:0] HR_EVERY_RST = 4'd3;

    typedef struct packed {
        logic [MS_W-1:0] now_ms;
        logic            link_up;
        logic            name_service_ok;
    } t_in_word;

    typedef struct packed {
        logic            checked;
        logic            reconnect;
        logic            hard_reset;
        logic            report_lost;
        logic            report_regained;
        logic            start_name_service;
        logic [MS_W-1:0] backoff_now_ms;
    } t_out_word;

    typedef struct packed {
        logic [MS_W-1:0]  grace_ms;
        logic [MS_W-1:0]  check_interval_ms;
        logic [MS_W-1:0]  backoff_initial_ms;
        logic [MS_W-1:0]  backoff_max_ms;
        logic [CNT_W-1:0] hard_reset_every;
    } t_cfg;

endpackage

### hdl/lrbt_in_if.sv
// lrbt_in_if: valid/ready channel carrying one poll word
// depends on lrbt_pkg
interface lrbt_in_if;
    logic                valid;
    logic                ready;
    lrbt_pkg::t_in_word  data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

### hdl/lrbt_out_if.sv
// lrbt_out_if: valid/ready channel carrying one result word
// depends on lrbt_pkg
interface lrbt_out_if;
    logic                valid;
    logic                ready;
    lrbt_pkg::t_out_word data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

### hdl/link_reconnect_backoff_timer.sv
// link_reconnect_backoff_timer: top level with input and result registers
// depends on lrbt_pkg, lrbt_in_if, lrbt_out_if, lrbt_cfg, lrbt_core
//
// usage
// - i_in carries one poll word per handshake: millisecond time, link-up flag
//   and whether a name-service start would succeed
// - o_out carries exactly one result word per poll: check/reconnect/hard reset
//   requests, loss and regain reports and the backoff after the poll
// - the config port writes one register per cycle with i_cfg_we high;
//   index 0 grace, 1 check interval, 2 initial backoff, 3 backoff ceiling,
//   4 reconnects per hard reset; other indexes are ignored
// - a word accepted into the input register has its result captured in the
//   result register and shown on o_out; the evaluation between the two is
//   one pass of compare, double-and-clamp and compare logic
// - throughput: one poll per clock while o_out is not stalled, set by
//   that single evaluation stage
// - reset (synchronous, active low) empties both registers, clears the timer
//   state and loads the default configuration
// - when o_out stalls the result register holds; the input register still
//   takes one more word, then i_in.ready drops until the result is taken
module link_reconnect_backoff_timer #(
    parameter int unsigned TIME_BITS = lrbt_pkg::TIME_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    lrbt_in_if.sink                         i_in,
    lrbt_out_if.source                      o_out,
    input  logic                            i_cfg_we,
    input  logic [lrbt_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [lrbt_pkg::CFG_DATA_W-1:0] i_cfg_wdata
);

    // input register
    logic                r_in_valid;
    lrbt_pkg::t_in_word  r_in_word;
    // result register
    logic                r_out_valid;
    lrbt_pkg::t_out_word r_out_word;

    lrbt_pkg::t_cfg      w_cfg;
    lrbt_pkg::t_out_word w_res;
    logic                w_adv;   // result register can take a new word
    logic                w_fire;  // evaluate the buffered poll this cycle
    logic                w_in_ready;

    assign w_adv      = !r_out_valid || o_out.ready;
    assign w_fire     = r_in_valid && w_adv;
    assign w_in_ready = !r_in_valid || w_adv;
    assign i_in.ready = w_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_in_ready) begin
                r_in_valid <= i_in.valid;
            end
            if (w_adv) begin
                r_out_valid <= r_in_valid;
            end
        end
    end

    // payload registers carry no reset
    always_ff @(posedge i_clk) begin
        if (i_in.valid && w_in_ready) begin
            r_in_word <= i_in.data;
        end
        if (w_fire) begin
            r_out_word <= w_res;
        end
    end

    lrbt_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (w_cfg)
    );

    // state advances only when the poll's result is captured
    lrbt_core #(
        .TIME_BITS (TIME_BITS)
    ) u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (w_fire),
        .i_word  (r_in_word),
        .i_cfg   (w_cfg),
        .o_word  (w_res)
    );

    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out_word;

    // a reconnect or a report only comes from an evaluated check
    a_reconnect_checked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && (r_out_word.reconnect || r_out_word.report_lost ||
                        r_out_word.report_regained) |-> r_out_word.checked)
        else $error("reconnect or report without an evaluated check");

    // hard reset rides on a reconnect
    a_hard_with_reconnect: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out_word.hard_reset |-> r_out_word.reconnect)
        else $error("hard reset without reconnect");

    // up-link actions and down-link actions never mix in one result
    a_up_down_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && (r_out_word.start_name_service || r_out_word.report_regained)
        |-> !r_out_word.reconnect && !r_out_word.report_lost)
        else $error("link up and link down actions in one result");

    // a full input register behind a stalled result blocks new words
    a_stall_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && r_out_valid && !o_out.ready |-> !i_in.ready)
        else $error("input taken while both registers are full");

endmodule

### hdl/lrbt_cfg.sv
// lrbt_cfg: configuration register bank with plain write port
// depends on lrbt_pkg
module lrbt_cfg (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [lrbt_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [lrbt_pkg::CFG_DATA_W-1:0]     i_cfg_wdata,
    output lrbt_pkg::t_cfg                      o_cfg
);

    lrbt_pkg::t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.grace_ms           <= lrbt_pkg::GRACE_RST;
            r_cfg.check_interval_ms  <= lrbt_pkg::INTERVAL_RST;
            r_cfg.backoff_initial_ms <= lrbt_pkg::BO_INIT_RST;
            r_cfg.backoff_max_ms     <= lrbt_pkg::BO_MAX_RST;
            r_cfg.hard_reset_every   <= lrbt_pkg::HR_EVERY_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                lrbt_pkg::CFG_GRACE:    r_cfg.grace_ms           <= i_cfg_wdata;
                lrbt_pkg::CFG_INTERVAL: r_cfg.check_interval_ms  <= i_cfg_wdata;
                lrbt_pkg::CFG_BO_INIT:  r_cfg.backoff_initial_ms <= i_cfg_wdata;
                lrbt_pkg::CFG_BO_MAX:   r_cfg.backoff_max_ms     <= i_cfg_wdata;
                lrbt_pkg::CFG_HR_EVERY: begin
                    r_cfg.hard_reset_every <= i_cfg_wdata[lrbt_pkg::CNT_W-1:0];
                end
                default: ; // unused indexes are ignored
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

### hdl/lrbt_core.sv
// lrbt_core: timer state registers and the combinational poll evaluation
// depends on lrbt_pkg
module lrbt_core #(
    parameter int unsigned TIME_BITS = lrbt_pkg::TIME_BITS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_fire,
    input  lrbt_pkg::t_in_word  i_word,
    input  lrbt_pkg::t_cfg      i_cfg,
    output lrbt_pkg::t_out_word o_word
);

    localparam int unsigned MS_W = lrbt_pkg::MS_W;
    localparam int unsigned CW   = (TIME_BITS > MS_W) ? TIME_BITS : MS_W;

    logic [TIME_BITS-1:0]       r_last_check, n_last_check;
    logic [TIME_BITS-1:0]       r_last_retry, n_last_retry;
    logic [MS_W-1:0]            r_backoff,    n_backoff;
    logic [lrbt_pkg::CNT_W-1:0] r_retry_cnt,  n_retry_cnt;
    logic                       r_ns_running, n_ns_running;
    logic                       r_loss_rep,   n_loss_rep;

    logic [TIME_BITS-1:0]       w_tnow;
    logic [TIME_BITS-1:0]       w_chk_diff;
    logic [TIME_BITS-1:0]       w_rty_diff;
    logic [MS_W:0]              w_dbl;
    logic [lrbt_pkg::CNT_W-1:0] w_cnt_inc;
    lrbt_pkg::t_out_word        w_res;

    assign w_tnow     = TIME_BITS'(i_word.now_ms);
    assign w_chk_diff = w_tnow - r_last_check;
    assign w_rty_diff = w_tnow - r_last_retry;
    assign w_dbl      = {r_backoff, 1'b0};
    assign w_cnt_inc  = r_retry_cnt + lrbt_pkg::CNT_W'(1);

    always_comb begin
        n_last_check = r_last_check;
        n_last_retry = r_last_retry;
        n_backoff    = r_backoff;
        n_retry_cnt  = r_retry_cnt;
        n_ns_running = r_ns_running;
        n_loss_rep   = r_loss_rep;
        w_res        = '0;

        if (i_word.now_ms < i_cfg.grace_ms) begin
            // boot grace: only an up link clears the backoff
            if (i_word.link_up) begin
                n_backoff = '0;
            end
        end else if (CW'(w_chk_diff) >= CW'(i_cfg.check_interval_ms)) begin
            n_last_check  = w_tnow;
            w_res.checked = 1'b1;
            if (i_word.link_up) begin
                n_backoff = '0;
                if (r_loss_rep) begin
                    w_res.report_regained = 1'b1;
                    n_loss_rep            = 1'b0;
                end
                if (!r_ns_running) begin
                    w_res.start_name_service = 1'b1;
                    n_ns_running             = i_word.name_service_ok;
                end
            end else begin
                n_ns_running = 1'b0;
                if (!r_loss_rep) begin
                    w_res.report_lost = 1'b1;
                    n_loss_rep        = 1'b1;
                end
                if (r_backoff == '0) begin
                    n_backoff = i_cfg.backoff_initial_ms;
                end else if (w_dbl < {1'b0, i_cfg.backoff_max_ms}) begin
                    n_backoff = w_dbl[MS_W-1:0];
                end else begin
                    n_backoff = i_cfg.backoff_max_ms;
                end
                if (CW'(w_rty_diff) >= CW'(n_backoff)) begin
                    n_last_retry    = w_tnow;
                    w_res.reconnect = 1'b1;
                    if (w_cnt_inc >= i_cfg.hard_reset_every) begin
                        n_retry_cnt      = '0;
                        w_res.hard_reset = 1'b1;
                    end else begin
                        n_retry_cnt = w_cnt_inc;
                    end
                end
            end
        end
        w_res.backoff_now_ms = n_backoff;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_check <= '0;
            r_last_retry <= '0;
            r_backoff    <= '0;
            r_retry_cnt  <= '0;
            r_ns_running <= 1'b0;
            r_loss_rep   <= 1'b0;
        end else if (i_fire) begin
            r_last_check <= n_last_check;
            r_last_retry <= n_last_retry;
            r_backoff    <= n_backoff;
            r_retry_cnt  <= n_retry_cnt;
            r_ns_running <= n_ns_running;
            r_loss_rep   <= n_loss_rep;
        end
    end

    assign o_word = w_res;

endmodule

### tb/sv/link_reconnect_backoff_timer_test.sv
`timescale 1ns / 1ps
// link_reconnect_backoff_timer_test: self-checking bench with a directed table, random
// polls across several register settings and a poll-by-poll timer predictor
// depends on lrbt_pkg, lrbt_in_if, lrbt_out_if and link_reconnect_backoff_timer
module link_reconnect_backoff_timer_test;

    localparam int unsigned CYCLE_LIMIT = 400000;
    localparam int          N_DIRECTED  = 18;
    localparam int          N_PHASES    = 8;

    // one directed poll; want is only meaningful where typed is set
    typedef struct packed {
        logic [lrbt_pkg::MS_W-1:0] now;
        logic                      up;
        logic                      ns_ok;
        logic                      typed;
        lrbt_pkg::t_out_word       want;
    } t_directed_row;

    localparam lrbt_pkg::t_out_word NO_WANT = '0;

    // fields of want: checked, reconnect, hard_reset, report_lost, report_regained,
    // start_name_service, backoff_now_ms; runs with the reset configuration
    localparam t_directed_row DIRECTED [N_DIRECTED] = '{
        // inside the boot grace period nothing is evaluated
        '{32'd0,         1'b0, 1'b0, 1'b1, '{1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 32'd0}},
        '{32'd29999,     1'b1, 1'b1, 1'b1, '{1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 32'd0}},
        // first check after grace: loss reported, initial backoff, immediate retry
        '{32'd30000,     1'b0, 1'b0, 1'b1, '{1'b1, 1'b1, 1'b0, 1'b1, 1'b0, 1'b0, 32'd5000}},
        // one ms short of the check interval: skipped, backoff shown as is
        '{32'd34999,     1'b0, 1'b0, 1'b1, '{1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 32'd5000}},
        // doubling up to the ceiling, retries once the backoff has elapsed
        '{32'd35000,     1'b0, 1'b0, 1'b0, NO_WANT},
        '{32'd45000,     1'b0, 1'b1, 1'b0, NO_WANT},
        '{32'd65000,     1'b0, 1'b0, 1'b0, NO_WANT},
        '{32'd105000,    1'b0, 1'b1, 1'b0, NO_WANT},
        // third reconnect also asks for a stack hard reset
        '{32'd165000,    1'b0, 1'b0, 1'b0, NO_WANT},
        // link back: regain report, name service start fails, then succeeds
        '{32'd170000,    1'b1, 1'b0, 1'b0, NO_WANT},
        '{32'd175000,    1'b1, 1'b1, 1'b0, NO_WANT},
        '{32'd180000,    1'b1, 1'b0, 1'b0, NO_WANT},
        '{32'd180001,    1'b0, 1'b1, 1'b1, '{1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 32'd0}},
        // top of the time range, then wrap back below the grace limit
        '{32'hFFFF_FFFF, 1'b0, 1'b1, 1'b0, NO_WANT},
        '{32'd0,         1'b0, 1'b0, 1'b1, '{1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 32'd5000}},
        // difference across the wrap
        '{32'd30000,     1'b0, 1'b0, 1'b0, NO_WANT},
        '{32'd40000,     1'b1, 1'b1, 1'b0, NO_WANT},
        '{32'hFFFF_FFFF, 1'b1, 1'b0, 1'b0, NO_WANT}
    };

    // register settings of the random part; field order grace, interval,
    // initial backoff, ceiling, reconnects per hard reset
    localparam lrbt_pkg::t_cfg PHASE_CFG [N_PHASES] = '{
        '{32'd1000,      32'd50,        32'd40,        32'd700,       4'd3},
        // zero interval, zero initial backoff, hard reset on every reconnect
        '{32'd0,         32'd0,         32'd0,         32'd100,       4'd0},
        // doubling runs into the top of the 32-bit range
        '{32'd0,         32'd1,         32'd1,         32'hFFFF_FFFF, 4'd15},
        // hard reset spacing lowered below a count left from the phase before
        '{32'd200,       32'd20,        32'd10,        32'd160,       4'd2},
        // initial backoff above the ceiling
        '{32'd0,         32'd30,        32'hFFFF_FFFF, 32'd1,         4'd1},
        '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 4'd15},
        '{lrbt_pkg::GRACE_RST, lrbt_pkg::INTERVAL_RST, lrbt_pkg::BO_INIT_RST,
          lrbt_pkg::BO_MAX_RST, lrbt_pkg::HR_EVERY_RST},
        '{32'd0,         32'd8,         32'd4,         32'd64,        4'd4}
    };
    // typical time advance per poll, in ms
    localparam logic [31:0] PHASE_STEP [N_PHASES] = '{
        32'd60, 32'd8, 32'h0400_0000, 32'd25, 32'd40, 32'h4000_0000, 32'd8000, 32'd10
    };
    localparam int PHASE_ITEMS [N_PHASES] = '{150, 150, 150, 150, 140, 40, 140, 140};
    // link toggles with probability 1/n per poll
    localparam int PHASE_FLIP  [N_PHASES] = '{6, 5, 40, 6, 8, 4, 6, 6};
    // idle chances in percent; phase two is a stretch without any, the last one is calm
    localparam int PHASE_GAP   [N_PHASES] = '{20, 35, 0, 15, 40, 10, 25, 0};
    localparam int PHASE_STALL [N_PHASES] = '{25, 10, 0, 40, 15, 30, 20, 0};

    logic                            i_clk = 1'b0;
    logic                            i_rst_n;
    logic                            cfg_we;
    logic [lrbt_pkg::CFG_IDX_W-1:0]  cfg_idx;
    logic [lrbt_pkg::CFG_DATA_W-1:0] cfg_wdata;

    lrbt_in_if  poll_ch ();
    lrbt_out_if result_ch ();

    // side info travelling with the poll word: a typed-in expectation
    logic                row_typed;
    lrbt_pkg::t_out_word row_want;

    // predictor copy of the configuration and timer state
    lrbt_pkg::t_cfg             cfg_shadow;
    logic [lrbt_pkg::MS_W-1:0]  tm_last_check;
    logic [lrbt_pkg::MS_W-1:0]  tm_last_retry;
    logic [lrbt_pkg::MS_W-1:0]  tm_backoff;
    logic [lrbt_pkg::CNT_W-1:0] tm_retries;
    logic                       tm_ns_running;
    logic                       tm_loss_seen;

    lrbt_pkg::t_out_word pending_results [$];
    int                  fail_count = 0;
    int                  result_idx = 0;
    int unsigned         cycle_count = 0;
    int                  stall_pct = 0;
    int                  stall_left = 0;

    link_reconnect_backoff_timer u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (poll_ch),
        .o_out       (result_ch),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_wdata (cfg_wdata)
    );

    always #5 i_clk = ~i_clk;

    // random idle burst length, zero when no burst is drawn
    function automatic int idle_burst(input int pct);
        return ($urandom_range(99) < pct) ? int'($urandom_range(1, 11)) : 0;
    endfunction

    // one poll through the timer: grace test, interval gate, then either the
    // up path (clear backoff, regain, name service) or the down path
    function automatic lrbt_pkg::t_out_word advance_timer(input lrbt_pkg::t_in_word p);
        lrbt_pkg::t_out_word       r;
        logic [lrbt_pkg::MS_W-1:0] since_check;
        logic [lrbt_pkg::MS_W-1:0] since_retry;
        logic [lrbt_pkg::MS_W:0]   doubled;
        r = '0;
        since_check = p.now_ms - tm_last_check;
        if (p.now_ms < cfg_shadow.grace_ms) begin
            if (p.link_up) tm_backoff = '0;
        end else if (since_check >= cfg_shadow.check_interval_ms) begin
            tm_last_check = p.now_ms;
            r.checked = 1'b1;
            if (p.link_up) begin
                tm_backoff = '0;
                if (tm_loss_seen) begin
                    r.report_regained = 1'b1;
                    tm_loss_seen = 1'b0;
                end
                if (!tm_ns_running) begin
                    r.start_name_service = 1'b1;
                    if (p.name_service_ok) tm_ns_running = 1'b1;
                end
            end else begin
                tm_ns_running = 1'b0;
                if (!tm_loss_seen) begin
                    r.report_lost = 1'b1;
                    tm_loss_seen = 1'b1;
                end
                // first failure loads the initial value as is, later ones double
                // and clamp; the extra bit keeps the doubling from wrapping
                if (tm_backoff == '0) begin
                    tm_backoff = cfg_shadow.backoff_initial_ms;
                end else begin
                    doubled = {tm_backoff, 1'b0};
                    tm_backoff = (doubled < {1'b0, cfg_shadow.backoff_max_ms}) ?
                                 doubled[lrbt_pkg::MS_W-1:0] : cfg_shadow.backoff_max_ms;
                end
                since_retry = p.now_ms - tm_last_retry;
                if (since_retry >= tm_backoff) begin
                    tm_last_retry = p.now_ms;
                    r.reconnect = 1'b1;
                    tm_retries = tm_retries + lrbt_pkg::CNT_W'(1);
                    if (tm_retries >= cfg_shadow.hard_reset_every) begin
                        tm_retries = '0;
                        r.hard_reset = 1'b1;
                    end
                end
            end
        end
        r.backoff_now_ms = tm_backoff;
        return r;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("error: %s (t=%0t)", msg, $realtime);
        fail_count++;
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want)
            report_mismatch($sformatf("result %0d field %s: expected %0d, got %0d",
                                      result_idx, name, want, got));
    endtask

    task automatic check_flag(input string name, input logic want, input logic got);
        if (got !== want)
            report_mismatch($sformatf("result %0d field %s: expected %0d, got %0d",
                                      result_idx, name, want, got));
    endtask

    // one register write; the shadow copy follows at once since the block is idle
    task automatic write_reg(input logic [lrbt_pkg::CFG_IDX_W-1:0] idx,
                             input logic [31:0] val);
        @(negedge i_clk);
        cfg_we    <= 1'b1;
        cfg_idx   <= idx;
        cfg_wdata <= val;
        case (idx)
            lrbt_pkg::CFG_GRACE:    cfg_shadow.grace_ms           = val;
            lrbt_pkg::CFG_INTERVAL: cfg_shadow.check_interval_ms  = val;
            lrbt_pkg::CFG_BO_INIT:  cfg_shadow.backoff_initial_ms = val;
            lrbt_pkg::CFG_BO_MAX:   cfg_shadow.backoff_max_ms     = val;
            lrbt_pkg::CFG_HR_EVERY: cfg_shadow.hard_reset_every   = val[lrbt_pkg::CNT_W-1:0];
            default: ;
        endcase
    endtask

    // drain every pending result, give the pipeline a moment, then reprogram
    task automatic apply_config(input lrbt_pkg::t_cfg c);
        @(negedge i_clk);
        poll_ch.valid <= 1'b0;
        while (pending_results.size() != 0) @(negedge i_clk);
        repeat (3) @(negedge i_clk);
        write_reg(lrbt_pkg::CFG_GRACE,    c.grace_ms);
        write_reg(lrbt_pkg::CFG_INTERVAL, c.check_interval_ms);
        write_reg(lrbt_pkg::CFG_BO_INIT,  c.backoff_initial_ms);
        write_reg(lrbt_pkg::CFG_BO_MAX,   c.backoff_max_ms);
        write_reg(lrbt_pkg::CFG_HR_EVERY, {28'd0, c.hard_reset_every});
        @(negedge i_clk);
        cfg_we <= 1'b0;
    endtask

    // present one poll word and return right after the edge that takes it;
    // a gap or a hold lowers valid first
    task automatic send_poll(input lrbt_pkg::t_in_word w, input logic typed,
                             input lrbt_pkg::t_out_word want,
                             input int gap, input bit hold);
        @(negedge i_clk);
        if (gap > 0 || hold) begin
            poll_ch.valid <= 1'b0;
            repeat ((gap > 0) ? gap : 1) @(negedge i_clk);
            // hold: wait until the block has returned every pending result
            while (hold && pending_results.size() != 0) @(negedge i_clk);
        end
        poll_ch.valid <= 1'b1;
        poll_ch.data  <= w;
        row_typed     <= typed;
        row_want      <= want;
        do @(posedge i_clk); while (!poll_ch.ready);
    endtask

    // result side stalls in random bursts
    always @(negedge i_clk) begin
        if (stall_left == 0) stall_left = idle_burst(stall_pct);
        if (stall_left > 0) begin
            result_ch.ready <= 1'b0;
            stall_left--;
        end else begin
            result_ch.ready <= 1'b1;
        end
    end

    // scoreboard: compare results first, since a word taken at this edge
    // cannot have its result out at the same edge, then predict the new one
    always @(posedge i_clk) begin
        lrbt_pkg::t_out_word want;
        lrbt_pkg::t_out_word got;
        lrbt_pkg::t_out_word pred;
        if (i_rst_n) begin
            if (result_ch.valid && result_ch.ready) begin
                got = result_ch.data;
                if (pending_results.size() == 0) begin
                    report_mismatch($sformatf("result word %h with no poll pending", got));
                end else begin
                    want = pending_results.pop_front();
                    check_flag("checked",            want.checked,            got.checked);
                    check_flag("reconnect",          want.reconnect,          got.reconnect);
                    check_flag("hard_reset",         want.hard_reset,         got.hard_reset);
                    check_flag("report_lost",        want.report_lost,        got.report_lost);
                    check_flag("report_regained",    want.report_regained,
                               got.report_regained);
                    check_flag("start_name_service", want.start_name_service,
                               got.start_name_service);
                    check_field("backoff_now_ms",    want.backoff_now_ms,
                                got.backoff_now_ms);
                end
                result_idx++;
            end
            if (poll_ch.valid && poll_ch.ready) begin
                // predictor always runs so its state stays in step
                pred = advance_timer(poll_ch.data);
                pending_results.push_back(row_typed ? row_want : pred);
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("link_reconnect_backoff_timer test failed");
            $finish;
        end
    end

    initial begin
        lrbt_pkg::t_in_word poll;
        logic [31:0]        now_cur;
        logic               link_cur;
        int                 ph;
        int                 n;
        int                 r;
        // every input known from time zero
        i_rst_n         = 1'b0;
        poll_ch.valid   = 1'b0;
        poll_ch.data    = '0;
        result_ch.ready = 1'b0;
        cfg_we          = 1'b0;
        cfg_idx         = '0;
        cfg_wdata       = '0;
        row_typed       = 1'b0;
        row_want        = '0;
        // predictor starts from the reset state
        cfg_shadow    = '{lrbt_pkg::GRACE_RST, lrbt_pkg::INTERVAL_RST, lrbt_pkg::BO_INIT_RST,
                          lrbt_pkg::BO_MAX_RST, lrbt_pkg::HR_EVERY_RST};
        tm_last_check = '0;
        tm_last_retry = '0;
        tm_backoff    = '0;
        tm_retries    = '0;
        tm_ns_running = 1'b0;
        tm_loss_seen  = 1'b0;

        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed table under the reset configuration
        stall_pct = 20;
        for (n = 0; n < N_DIRECTED; n++) begin
            poll = '{DIRECTED[n].now, DIRECTED[n].up, DIRECTED[n].ns_ok};
            send_poll(poll, DIRECTED[n].typed, DIRECTED[n].want, idle_burst(20), 1'b0);
        end

        // random polls: mostly forward time in steps near the check interval,
        // with repeats, long jumps, arbitrary times and near-wrap times mixed in
        now_cur  = '0;
        link_cur = 1'b0;
        for (ph = 0; ph < N_PHASES; ph++) begin
            stall_pct = PHASE_STALL[ph];
            apply_config(PHASE_CFG[ph]);
            for (n = 0; n < PHASE_ITEMS[ph]; n++) begin
                r = $urandom_range(99);
                if (r < 5) begin
                    // same time again
                end else if (r < 75) begin
                    now_cur = now_cur + $urandom_range(0, PHASE_STEP[ph]);
                end else if (r < 88) begin
                    now_cur = now_cur + PHASE_STEP[ph] + $urandom_range(0, PHASE_STEP[ph]);
                end else if (r < 96) begin
                    now_cur = $urandom;
                end else begin
                    now_cur = 32'hFFFF_FFFF - $urandom_range(0, PHASE_STEP[ph]);
                end
                // link state comes in runs so the backoff can build up
                if ($urandom_range(PHASE_FLIP[ph] - 1) == 0) link_cur = ~link_cur;
                poll = '{now_cur, link_cur, 1'($urandom_range(1))};
                // the last phase runs without any idle cycle
                send_poll(poll, 1'b0, NO_WANT, idle_burst(PHASE_GAP[ph]),
                          ((n % 50) == 49) && (ph != N_PHASES - 1));
            end
        end

        @(negedge i_clk);
        poll_ch.valid <= 1'b0;
        while (pending_results.size() != 0) @(negedge i_clk);
        repeat (5) @(posedge i_clk);
        if (fail_count == 0 && pending_results.size() == 0) begin
            $display("link_reconnect_backoff_timer test passed");
        end else begin
            $display("link_reconnect_backoff_timer test failed");
        end
        $finish;
    end
endmodule
